// ===== design/lkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
  } out_word_t;

  // One stored entry.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  // Running match / read data, passed from the old end of the row toward cell 0.
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] rd;
  } fwd_t;

  // Per-word control broadcast to every cell.
  typedef struct packed {
    logic step;   // word accepted this cycle
    logic hit;    // key found somewhere in the row
    logic ins;    // set that missed: insert at cell 0
    logic evict;  // insert drops the oldest valid entry
  } ctl_t;

endpackage

`default_nettype wire

// ===== design/lkv_cell.sv =====
// One recency slot: holds an entry, compares the key, shifts toward the old end.
`timescale 1ns / 1ps
`default_nettype none

module lkv_cell import lkv_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [KEY_W-1:0] lookup_key,
  input  wire ctl_t             ctl,
  input  wire entry_t           prev_ent,  // younger neighbor (or new entry at cell 0)
  input  wire fwd_t             fwd_in,    // from older neighbor
  output fwd_t                  fwd_out,
  output entry_t                cur_ent,
  output logic                  match
);

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  logic             shift;

  assign match       = valid_r && (key_r == lookup_key);
  assign fwd_out.hit = match | fwd_in.hit;
  assign fwd_out.rd  = fwd_in.rd | (match ? value_r : '0);
  assign cur_ent     = '{valid: valid_r, key: key_r, value: value_r};

  // Hit: slots from here to the hit slot age by one.
  // Insert: valid slots age; without eviction the first free slot fills too.
  always_comb begin
    shift = 1'b0;
    if (ctl.step) begin
      if (ctl.hit) begin
        shift = fwd_out.hit;
      end else if (ctl.ins) begin
        shift = ctl.evict ? valid_r : (valid_r | prev_ent.valid);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= prev_ent.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key_r   <= prev_ent.key;
      value_r <= prev_ent.value;
    end
  end

endmodule

`default_nettype wire

// ===== design/lru_key_value_cache_top.sv =====
// Top level of the fully associative LRU key-value cache.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one request word:
//   op (get or set), key and value. Result channel (out_valid / out_stall /
//   out_data) returns exactly one word per request: hit, read_value (get hit
//   only, else zero) and evicted (set insert that dropped the oldest entry).
//   A word moves at a clock edge with valid high and stall low.
//   The result is registered and shows in the cycle after the request is
//   taken. Throughput: one request per cycle unless the result is stalled.
//   The whole lookup and the row's recency shift end as the word is taken.
//   A stalled result holds in the output register; the input is stalled only
//   while that register is full and not being drained, so the next request is
//   taken in the same cycle the pending result leaves.
//   Reset (rst_n low, synchronous) empties the store and sets capacity to 16.
//   cfg_wr_en / cfg_wr_data write the capacity register (0 acts as 1, values
//   above ENTRIES act as ENTRIES); write it only while the block is idle.
//   Lowering capacity below the fill drops nothing; later inserts replace.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache_top import lkv_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_word_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_word_t             out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [CAP_W-1:0] cfg_wr_data
);

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [CAP_W-1:0] cap_r;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             out_valid_r;
  out_word_t        out_r;

  logic             accept;
  ctl_t             ctl;
  entry_t           new_ent;
  logic [CMP_W-1:0] cap_ext, eff_cap;
  logic             full;

  entry_t           ent   [ENTRIES];
  fwd_t             fwd   [ENTRIES+1];
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] valid_vec;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // effective capacity: clamp into 1 .. ENTRIES
  assign cap_ext = CMP_W'(cap_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign full = CMP_W'(occ_r) >= eff_cap;

  assign fwd[ENTRIES] = '0;

  assign ctl.step  = accept;
  assign ctl.hit   = fwd[0].hit;
  assign ctl.ins   = (in_data.op == OP_SET) && !fwd[0].hit;
  assign ctl.evict = full;

  // cell 0 takes the requested entry; on a get hit it is the entry itself
  assign new_ent.valid = 1'b1;
  assign new_ent.key   = in_data.key;
  assign new_ent.value = (in_data.op == OP_GET) ? fwd[0].rd : in_data.value;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      lkv_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_key (in_data.key),
        .ctl        (ctl),
        .prev_ent   (new_ent),
        .fwd_in     (fwd[i+1]),
        .fwd_out    (fwd[i]),
        .cur_ent    (ent[i]),
        .match      (match_vec[i])
      );
    end else begin : g_body
      lkv_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_key (in_data.key),
        .ctl        (ctl),
        .prev_ent   (ent[i-1]),
        .fwd_in     (fwd[i+1]),
        .fwd_out    (fwd[i]),
        .cur_ent    (ent[i]),
        .match      (match_vec[i])
      );
    end
    assign valid_vec[i] = ent[i].valid;
  end

  always_comb begin
    occ_nxt = occ_r;
    if (accept && ctl.ins && !full) begin
      occ_nxt = occ_r + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      occ_r <= occ_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r.hit        <= fwd[0].hit;
      out_r.read_value <= (in_data.op == OP_GET) ? fwd[0].rd : '0;
      out_r.evicted    <= ctl.ins && full;
    end
  end

  // ---- assertions ----

  // fill count tracks the valid cells
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(occ_r))
    else $error("occupancy does not match valid cells");

  // keys are unique, so at most one cell matches
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("duplicate key in cell row");

  // a taken set always ends up most recent in cell 0
  a_set_head: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.op == OP_SET |=>
      ent[0].valid && ent[0].key == $past(in_data.key)
      && ent[0].value == $past(in_data.value))
    else $error("set word not at head of row");

  // an eviction only happens on a miss
  a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.hit && out_r.evicted))
    else $error("hit and evicted both set");

endmodule

`default_nettype wire
